@@ src/ppsd_pkg.sv @@
// Shared types and constants for the ping-pong stereo delay.
// No dependencies; ppsd_mac and ping_pong_stereo_delay import this package.
package ppsd_pkg;

  localparam int SAMPLE_BITS_DEF  = 24;
  localparam int BUFFER_DEPTH_DEF = 131072;

  localparam int GAIN_W      = 16;
  localparam int DELAY_W     = 17;
  localparam int CFG_DATA_W  = 17;
  localparam int CFG_IDX_W   = 2;
  localparam int FRAC_BITS   = 14;
  localparam int ROUND_HALF  = 8192;

  localparam int DELAY_RST    = 48000;
  localparam int FEEDBACK_RST = 8192;
  localparam int DRY_RST      = 16384;
  localparam int WET_RST      = 8192;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DELAY    = 2'd0,
    REG_FEEDBACK = 2'd1,
    REG_DRY      = 2'd2,
    REG_WET      = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [GAIN_W-1:0] feedback;
    logic [GAIN_W-1:0] dry;
    logic [GAIN_W-1:0] wet;
  } gains_t;

endpackage

@@ src/ppsd_ram.sv @@
// Simple dual-port echo memory: one write port, one registered read port.
// A read and a write to the same address at one edge return the old word.
module ppsd_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 48
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ src/ppsd_mac.sv @@
// Gain multipliers, product register and round/saturate logic of the delay.
// Depends on ppsd_pkg for the gain struct and the fixed-point constants.
module ppsd_mac #(
  parameter int SAMPLE_BITS = ppsd_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          load,
  input  ppsd_pkg::gains_t              gains,
  input  logic signed [SAMPLE_BITS-1:0] left_in,
  input  logic signed [SAMPLE_BITS-1:0] right_in,
  input  logic signed [SAMPLE_BITS-1:0] echo_left,
  input  logic signed [SAMPLE_BITS-1:0] echo_right,
  output logic signed [SAMPLE_BITS-1:0] store_left,
  output logic signed [SAMPLE_BITS-1:0] store_right,
  output logic signed [SAMPLE_BITS-1:0] left_out,
  output logic signed [SAMPLE_BITS-1:0] right_out
);
  import ppsd_pkg::*;

  localparam int S      = SAMPLE_BITS;
  localparam int G_W    = GAIN_W + 1;
  localparam int ACC_W  = S + 20;
  localparam int Q_W    = ACC_W - FRAC_BITS;

  localparam logic signed [Q_W-1:0] Q_MAX = {{(Q_W-S+1){1'b0}}, {(S-1){1'b1}}};
  localparam logic signed [Q_W-1:0] Q_MIN = {{(Q_W-S+1){1'b1}}, {(S-1){1'b0}}};

  function automatic logic signed [S-1:0] round_sat(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0] v;
    logic signed [Q_W-1:0]   q;
    v = acc + $signed(ACC_W'(ROUND_HALF));
    // Arithmetic shift floors, which is what rounding half up needs.
    q = v[ACC_W-1:FRAC_BITS];
    if (q > Q_MAX) begin
      q = Q_MAX;
    end else if (q < Q_MIN) begin
      q = Q_MIN;
    end
    return q[S-1:0];
  endfunction

  logic signed [G_W-1:0] fb_g;
  logic signed [G_W-1:0] dry_g;
  logic signed [G_W-1:0] wet_g;
  logic signed [S:0]     mono;
  logic signed [S+1:0]   fb_sum;

  logic signed [S+G_W+1:0] p_fb_left;
  logic signed [S+G_W-1:0] p_fb_right;
  logic signed [S+G_W:0]   p_dry;
  logic signed [S+G_W-1:0] p_wet_left;
  logic signed [S+G_W-1:0] p_wet_right;

  logic signed [ACC_W-1:0] acc_left;
  logic signed [ACC_W-1:0] acc_right;

  assign fb_g   = $signed({1'b0, gains.feedback});
  assign dry_g  = $signed({1'b0, gains.dry});
  assign wet_g  = $signed({1'b0, gains.wet});
  assign mono   = (S+1)'(left_in) + (S+1)'(right_in);
  assign fb_sum = (S+2)'(mono) + (S+2)'(echo_right);

  always_ff @(posedge clk) begin
    if (load) begin
      p_fb_left   <= (S+G_W+2)'(fb_g) * (S+G_W+2)'(fb_sum);
      p_fb_right  <= (S+G_W)'(fb_g) * (S+G_W)'(echo_left);
      p_dry       <= (S+G_W+1)'(dry_g) * (S+G_W+1)'(mono);
      p_wet_left  <= (S+G_W)'(wet_g) * (S+G_W)'(echo_left);
      p_wet_right <= (S+G_W)'(wet_g) * (S+G_W)'(echo_right);
    end
  end

  assign acc_left  = ACC_W'(p_dry) + ACC_W'(p_wet_left);
  assign acc_right = ACC_W'(p_dry) + ACC_W'(p_wet_right);

  assign store_left  = round_sat(ACC_W'(p_fb_left));
  assign store_right = round_sat(ACC_W'(p_fb_right));
  assign left_out    = round_sat(acc_left);
  assign right_out   = round_sat(acc_right);

endmodule

@@ src/ping_pong_stereo_delay.sv @@
// Top level of the ping-pong stereo delay: handshakes, positions, pipeline control.
// Depends on ppsd_pkg, ppsd_ram and ppsd_mac.
//
// Each input word (left and right sample) passes through the input register, the
// product register and the output register and leaves as one output word. With
// a delay of zero or of three samples or more a word is taken every clock while
// the output is not stalled. Delays of one and two close a loop through the echo
// memory, the multipliers and the rounding stage: the input is held off until the
// word in flight has written its slot. The echo memory is not cleared after reset:
// entries not yet written since reset read as zero by comparing the read position
// with the write position and a wrapped flag. BUFFER_DEPTH must be a power of two.
module ping_pong_stereo_delay #(
  parameter int BUFFER_DEPTH = ppsd_pkg::BUFFER_DEPTH_DEF,
  parameter int SAMPLE_BITS  = ppsd_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                           clk,
  input  logic                                           rst,
  input  logic                                           cfg_we,
  input  logic [ppsd_pkg::CFG_IDX_W-1:0]                 cfg_addr,
  input  logic [ppsd_pkg::CFG_DATA_W-1:0]                cfg_wdata,
  input  logic                                           s_axis_tvalid,
  output logic                                           s_axis_tready,
  // Fields from bit 0: left_in, right_in, zero padding.
  input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]             s_axis_tdata,
  output logic                                           m_axis_tvalid,
  input  logic                                           m_axis_tready,
  // Fields from bit 0: left_out, right_out, zero padding.
  output logic [((2*SAMPLE_BITS+7)/8)*8-1:0]             m_axis_tdata
);
  import ppsd_pkg::*;

  localparam int S      = SAMPLE_BITS;
  localparam int ADDR_W = $clog2(BUFFER_DEPTH);
  localparam int DATA_W = ((2*SAMPLE_BITS+7)/8)*8;

  gains_t gains;

  logic [ADDR_W-1:0] wp;
  logic [ADDR_W-1:0] rd_pos;
  logic              wrapped;

  logic              s1_valid;
  logic [ADDR_W-1:0] s1_wp;
  logic              s1_hit;
  logic signed [S-1:0] s1_left;
  logic signed [S-1:0] s1_right;

  logic              s2_valid;
  logic [ADDR_W-1:0] s2_wp;

  logic              out_valid;
  logic signed [S-1:0] out_left;
  logic signed [S-1:0] out_right;

  logic out_load;
  logic s2_load;
  logic s2_adv;
  logic s1_load;
  logic hazard;
  logic accept;

  logic [2*S-1:0]      ram_q;
  logic signed [S-1:0] echo_left;
  logic signed [S-1:0] echo_right;
  logic signed [S-1:0] store_left;
  logic signed [S-1:0] store_right;
  logic signed [S-1:0] mac_left;
  logic signed [S-1:0] mac_right;

  assign out_load = !out_valid || m_axis_tready;
  assign s2_load  = !s2_valid || out_load;
  assign s2_adv   = s2_valid && out_load;
  assign s1_load  = !s1_valid || s2_load;

  // A word still in flight that will write the slot we are about to read holds
  // off the read until its write has landed.
  assign hazard = (s1_valid && (s1_wp == rd_pos)) || (s2_valid && (s2_wp == rd_pos));

  assign s_axis_tready = s1_load && !hazard;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Configuration registers. The delay is kept as a read position that trails
  // the write position.
  always_ff @(posedge clk) begin
    if (rst) begin
      gains.feedback <= GAIN_W'(FEEDBACK_RST);
      gains.dry      <= GAIN_W'(DRY_RST);
      gains.wet      <= GAIN_W'(WET_RST);
      wp             <= '0;
      rd_pos         <= ADDR_W'(0) - ADDR_W'(DELAY_RST);
      wrapped        <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_FEEDBACK: gains.feedback <= cfg_wdata[GAIN_W-1:0];
          REG_DRY:      gains.dry      <= cfg_wdata[GAIN_W-1:0];
          REG_WET:      gains.wet      <= cfg_wdata[GAIN_W-1:0];
          default:      ;
        endcase
      end
      // A word taken at the same edge already moves the write position on.
      if (cfg_we && (cfg_addr == REG_DELAY)) begin
        rd_pos <= wp + ADDR_W'(accept) - ADDR_W'(cfg_wdata[DELAY_W-1:0]);
      end else if (accept) begin
        rd_pos <= rd_pos + ADDR_W'(1);
      end
      if (accept) begin
        wp <= wp + ADDR_W'(1);
        if (wp == ADDR_W'(BUFFER_DEPTH - 1)) begin
          wrapped <= 1'b1;
        end
      end
    end
  end

  // Pipeline valid flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_load) begin
        s1_valid <= accept;
      end
      if (s2_load) begin
        s2_valid <= s1_valid;
      end
      if (out_load) begin
        out_valid <= s2_valid;
      end
    end
  end

  // Pipeline payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_left  <= $signed(s_axis_tdata[S-1:0]);
      s1_right <= $signed(s_axis_tdata[2*S-1:S]);
      s1_wp    <= wp;
      // Slots not written since reset read as zero.
      s1_hit   <= wrapped || (rd_pos < wp);
    end
    if (s2_load) begin
      s2_wp <= s1_wp;
    end
    if (out_load) begin
      out_left  <= mac_left;
      out_right <= mac_right;
    end
  end

  ppsd_ram #(
    .DEPTH (BUFFER_DEPTH),
    .WIDTH (2*S)
  ) u_ram (
    .clk   (clk),
    .we    (s2_adv),
    .waddr (s2_wp),
    .wdata ({store_right, store_left}),
    .re    (accept),
    .raddr (rd_pos),
    .rdata (ram_q)
  );

  assign echo_left  = s1_hit ? $signed(ram_q[S-1:0])   : '0;
  assign echo_right = s1_hit ? $signed(ram_q[2*S-1:S]) : '0;

  ppsd_mac #(
    .SAMPLE_BITS (S)
  ) u_mac (
    .clk         (clk),
    .load        (s2_load),
    .gains       (gains),
    .left_in     (s1_left),
    .right_in    (s1_right),
    .echo_left   (echo_left),
    .echo_right  (echo_right),
    .store_left  (store_left),
    .store_right (store_right),
    .left_out    (mac_left),
    .right_out   (mac_right)
  );

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = DATA_W'({out_right, out_left});

endmodule
